[rtl/mlds_pkg.sv]
// shared constants and field layout for the multi-list deque splice manager
package mlds_pkg;

  // default sizing
  localparam int LISTS_DEF = 128;
  localparam int ITEMS_DEF = 1024;

  // request and result field widths
  localparam int MODE_W = 3;
  localparam int LIST_FW = 7;
  localparam int ITEM_FW = 11;

  // request tdata layout, lowest field first
  localparam int IN_MODE_LSB = 0;
  localparam int IN_SRC_LSB = IN_MODE_LSB + MODE_W;
  localparam int IN_DST_LSB = IN_SRC_LSB + LIST_FW;
  localparam int IN_PROBE_LSB = IN_DST_LSB + LIST_FW;
  localparam int IN_USED_W = IN_PROBE_LSB + ITEM_FW;
  localparam int IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;

  // result tdata layout, lowest field first
  localparam int OUT_MOVED_LSB = 0;
  localparam int OUT_COUNT_LSB = OUT_MOVED_LSB + 1;
  localparam int OUT_HEAD_LSB = OUT_COUNT_LSB + ITEM_FW;
  localparam int OUT_TAIL_LSB = OUT_HEAD_LSB + ITEM_FW;
  localparam int OUT_PROBE_LSB = OUT_TAIL_LSB + ITEM_FW;
  localparam int OUT_USED_W = OUT_PROBE_LSB + ITEM_FW;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W = OUT_TDATA_W - OUT_USED_W;

  // request modes
  localparam logic [MODE_W-1:0] MODE_FRONT_TO_END = 3'd0;
  localparam logic [MODE_W-1:0] MODE_END_TO_FRONT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SPLICE_BEFORE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SPLICE_AFTER = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ = 3'd4;

endpackage

[rtl/multi_list_deque_splice_manager_core.sv]
// top level: list table and link memories with the request sequencer
// a request accepted in the idle state passes the read, execute and write states, then its result
//   is registered onto out_tvalid, through the output queue state while out_tready is low; the next
//   request is taken only after that, the source entry read feeding the destination and link reads
// reset: rst_n is synchronous; afterwards a clearing pass over the list table and link memories
//   loads list 0 with every item, in_tready stays low until it ends
module multi_list_deque_splice_manager_core
  import mlds_pkg::*;
#(
  parameter int LISTS = LISTS_DEF,
  parameter int ITEMS = ITEMS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // request channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // mode[2:0], src_list[9:3], dst_list[16:10], probe_item[27:17], zero fill
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // moved[0], src_count[11:1], src_head[22:12], src_tail[33:23], probe_next[44:34], zero fill
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  // list index, item and count widths
  localparam int LW = $clog2(LISTS);
  localparam int IW = $clog2(ITEMS + 1);
  localparam int CW = IW;
  // clearing pass covers the list table and the link memories together
  localparam int INIT_LEN = (LISTS > ITEMS + 1) ? LISTS : ITEMS + 1;
  localparam int CNTW = $clog2(INIT_LEN);

  // one list table entry
  typedef struct packed {
    logic [IW-1:0] head;
    logic [IW-1:0] tail;
    logic [CW-1:0] count;
  } lent_t;

  // one write into a link memory
  typedef struct packed {
    logic          we;
    logic [IW-1:0] addr;
    logic [IW-1:0] data;
  } lwr_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_WRITE,
    ST_OUTQ
  } state_t;

  // memories: list table, successor and predecessor links
  lent_t         list_mem [LISTS];
  logic [IW-1:0] next_mem [ITEMS+1];
  logic [IW-1:0] prev_mem [ITEMS+1];

  // registered read data, valid in the cycle after the address
  lent_t         list_rd_r;
  logic [IW-1:0] next_rd_r;
  logic [IW-1:0] prev_rd_r;

  // memory port controls
  logic [LW-1:0] lm_ra, lm_wa;
  logic          lm_we;
  lent_t         lm_wd;
  logic [IW-1:0] nm_ra, pm_ra;
  lwr_t          nm_w, pm_w;

  // sequencer registers
  state_t                  state_r, state_nxt;
  logic [CNTW-1:0]         cnt_r, cnt_nxt;
  logic [MODE_W-1:0]       mode_r, mode_nxt;
  logic [LIST_FW-1:0]      src_r, src_nxt;
  logic [LIST_FW-1:0]      dst_r, dst_nxt;
  logic [ITEM_FW-1:0]      probe_r, probe_nxt;
  lent_t                   ls_r, ls_nxt;      // source entry before the update
  logic                    l2_we_r, l2_we_nxt; // write state list write, destination
  lent_t                   l2_data_r, l2_data_nxt;
  lwr_t                    n2_r, n2_nxt;      // write state link writes
  lwr_t                    p2_r, p2_nxt;
  lent_t                   rep_r, rep_nxt;    // source entry as reported
  logic                    moved_r, moved_nxt;
  logic                    fwd_hit_r, fwd_hit_nxt;
  logic [IW-1:0]           fwd_data_r, fwd_data_nxt;
  logic                    probe_ok_r, probe_ok_nxt;
  logic [OUT_TDATA_W-1:0]  res_r, res_nxt;    // result parked while the output is full
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0]  out_data_r, out_data_nxt;

  // request fields
  logic [MODE_W-1:0]  in_mode;
  logic [LIST_FW-1:0] in_src, in_dst;
  logic [ITEM_FW-1:0] in_probe;

  assign in_mode  = in_tdata[IN_MODE_LSB +: MODE_W];
  assign in_src   = in_tdata[IN_SRC_LSB +: LIST_FW];
  assign in_dst   = in_tdata[IN_DST_LSB +: LIST_FW];
  assign in_probe = in_tdata[IN_PROBE_LSB +: ITEM_FW];

  // execute cycle: all reads are back, work out both write sets
  lent_t         ls, ld, db, ls1, ld2, rep;
  logic [IW-1:0] nx, pv, probe_idx;
  logic          same, s_ok, d_ok, go, moved, l2_we;
  lwr_t          n1, p1, n2, p2;
  logic          fwd_hit;
  logic [IW-1:0] fwd_data;

  always_comb begin
    ls        = ls_r;
    ld        = list_rd_r;
    nx        = next_rd_r;
    pv        = prev_rd_r;
    probe_idx = IW'(probe_r);
    same      = (src_r == dst_r);
    s_ok      = int'(src_r) < LISTS;
    d_ok      = int'(dst_r) < LISTS;
    go        = s_ok && d_ok && (ls.head != '0);
    db        = ld;
    ls1       = ls;
    ld2       = ld;
    n1        = '0;
    p1        = '0;
    n2        = '0;
    p2        = '0;
    moved     = 1'b0;
    l2_we     = 1'b0;
    case (mode_r)
      MODE_FRONT_TO_END: begin
        if (go) begin
          // unlink the head of src, append it to the end of dst
          moved     = 1'b1;
          l2_we     = 1'b1;
          ls1.head  = nx;
          ls1.tail  = (nx == '0) ? '0 : ls.tail;
          ls1.count = ls.count - CW'(1);
          db        = same ? ls1 : ld;
          ld2.head  = (db.tail == '0) ? ls.head : db.head;
          ld2.tail  = ls.head;
          ld2.count = db.count + CW'(1);
          n1        = '{we: 1'b1, addr: ls.head, data: '0};
          p1        = '{we: (nx != '0), addr: nx, data: '0};
          n2        = '{we: (db.tail != '0), addr: db.tail, data: ls.head};
          p2        = '{we: 1'b1, addr: ls.head, data: db.tail};
        end
      end
      MODE_END_TO_FRONT: begin
        if (go) begin
          // unlink the tail of src, push it onto the front of dst
          moved     = 1'b1;
          l2_we     = 1'b1;
          ls1.tail  = pv;
          ls1.head  = (pv == '0) ? '0 : ls.head;
          ls1.count = ls.count - CW'(1);
          db        = same ? ls1 : ld;
          ld2.head  = ls.tail;
          ld2.tail  = (db.head == '0) ? ls.tail : db.tail;
          ld2.count = db.count + CW'(1);
          n1        = '{we: (pv != '0), addr: pv, data: '0};
          p1        = '{we: 1'b1, addr: ls.tail, data: '0};
          n2        = '{we: 1'b1, addr: ls.tail, data: db.head};
          p2        = '{we: (db.head != '0), addr: db.head, data: ls.tail};
        end
      end
      MODE_SPLICE_BEFORE: begin
        if (go && !same) begin
          moved     = 1'b1;
          l2_we     = 1'b1;
          ls1       = '0;
          ld2.head  = ls.head;
          ld2.tail  = (ld.head == '0) ? ls.tail : ld.tail;
          ld2.count = ld.count + ls.count;
          n1        = '{we: 1'b1, addr: ls.tail, data: ld.head};
          p1        = '{we: (ld.head != '0), addr: ld.head, data: ls.tail};
        end
      end
      MODE_SPLICE_AFTER: begin
        if (go && !same) begin
          moved     = 1'b1;
          l2_we     = 1'b1;
          ls1       = '0;
          ld2.head  = (ld.tail == '0) ? ls.head : ld.head;
          ld2.tail  = ls.tail;
          ld2.count = ld.count + ls.count;
          n1        = '{we: (ld.tail != '0), addr: ld.tail, data: ls.head};
          p1        = '{we: 1'b1, addr: ls.head, data: ld.tail};
        end
      end
      default: begin
        // read only, and the unused codes
      end
    endcase

    // on a same-list move the destination write is the final source entry
    if (!moved) begin
      rep = ls;
    end else if (same) begin
      rep = ld2;
    end else begin
      rep = ls1;
    end
    if (!s_ok) begin
      rep = '0;
    end

    // the probe read sees neither write set, forward the later one first
    fwd_hit  = 1'b0;
    fwd_data = '0;
    if (n2.we && (n2.addr == probe_idx)) begin
      fwd_hit  = 1'b1;
      fwd_data = n2.data;
    end else if (n1.we && (n1.addr == probe_idx)) begin
      fwd_hit  = 1'b1;
      fwd_data = n1.data;
    end
  end

  // result word as it leaves the write cycle
  logic [IW-1:0]          probe_val;
  logic [OUT_TDATA_W-1:0] result;

  always_comb begin
    probe_val = '0;
    if (probe_ok_r) begin
      probe_val = fwd_hit_r ? fwd_data_r : next_rd_r;
    end
    result = {{OUT_PAD_W{1'b0}}, ITEM_FW'(probe_val), ITEM_FW'(rep_r.tail),
              ITEM_FW'(rep_r.head), ITEM_FW'(rep_r.count), moved_r};
  end

  // memory addressing and write selection
  always_comb begin
    lm_ra = (state_r == ST_IDLE) ? LW'(in_src) : LW'(dst_r);
    nm_ra = (state_r == ST_EXEC) ? probe_idx : list_rd_r.head;
    pm_ra = list_rd_r.tail;
    lm_we = 1'b0;
    lm_wa = LW'(src_r);
    lm_wd = '0;
    nm_w  = '0;
    pm_w  = '0;
    case (state_r)
      ST_INIT: begin
        // list 0 holds every item in order, links chain b-1 <- b -> b+1
        lm_we = int'(cnt_r) < LISTS;
        lm_wa = LW'(cnt_r);
        if (cnt_r == '0) begin
          lm_wd = '{head: IW'(1), tail: IW'(ITEMS), count: CW'(ITEMS)};
        end
        nm_w.we   = int'(cnt_r) <= ITEMS;
        nm_w.addr = IW'(cnt_r);
        nm_w.data = (cnt_r != '0 && int'(cnt_r) < ITEMS) ? IW'(cnt_r) + IW'(1) : '0;
        pm_w.we   = int'(cnt_r) <= ITEMS;
        pm_w.addr = IW'(cnt_r);
        pm_w.data = (cnt_r != '0) ? IW'(cnt_r) - IW'(1) : '0;
      end
      ST_EXEC: begin
        lm_we = moved;
        lm_wa = LW'(src_r);
        lm_wd = ls1;
        nm_w  = n1;
        pm_w  = p1;
      end
      ST_WRITE: begin
        lm_we = l2_we_r;
        lm_wa = LW'(dst_r);
        lm_wd = l2_data_r;
        nm_w  = n2_r;
        pm_w  = p2_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (lm_we) begin
      list_mem[lm_wa] <= lm_wd;
    end
    list_rd_r <= list_mem[lm_ra];
  end

  always_ff @(posedge clk) begin
    if (nm_w.we) begin
      next_mem[nm_w.addr] <= nm_w.data;
    end
    next_rd_r <= next_mem[nm_ra];
  end

  always_ff @(posedge clk) begin
    if (pm_w.we) begin
      prev_mem[pm_w.addr] <= pm_w.data;
    end
    prev_rd_r <= prev_mem[pm_ra];
  end

  // sequencer next state
  logic out_free;

  always_comb begin
    out_free      = !out_valid_r || out_tready;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    mode_nxt      = mode_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    probe_nxt     = probe_r;
    ls_nxt        = ls_r;
    l2_we_nxt     = l2_we_r;
    l2_data_nxt   = l2_data_r;
    n2_nxt        = n2_r;
    p2_nxt        = p2_r;
    rep_nxt       = rep_r;
    moved_nxt     = moved_r;
    fwd_hit_nxt   = fwd_hit_r;
    fwd_data_nxt  = fwd_data_r;
    probe_ok_nxt  = probe_ok_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_INIT: begin
        cnt_nxt = cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(INIT_LEN - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          mode_nxt  = in_mode;
          src_nxt   = in_src;
          dst_nxt   = in_dst;
          probe_nxt = in_probe;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        ls_nxt    = list_rd_r;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        l2_we_nxt    = l2_we;
        l2_data_nxt  = ld2;
        n2_nxt       = n2;
        p2_nxt       = p2;
        rep_nxt      = rep;
        moved_nxt    = moved;
        fwd_hit_nxt  = fwd_hit;
        fwd_data_nxt = fwd_data;
        probe_ok_nxt = (probe_r != '0) && (int'(probe_r) <= ITEMS);
        state_nxt    = ST_WRITE;
      end
      ST_WRITE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = result;
          state_nxt     = ST_IDLE;
        end else begin
          res_nxt   = result;
          state_nxt = ST_OUTQ;
        end
      end
      ST_OUTQ: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r     <= mode_nxt;
    src_r      <= src_nxt;
    dst_r      <= dst_nxt;
    probe_r    <= probe_nxt;
    ls_r       <= ls_nxt;
    l2_we_r    <= l2_we_nxt;
    l2_data_r  <= l2_data_nxt;
    n2_r       <= n2_nxt;
    p2_r       <= p2_nxt;
    rep_r      <= rep_nxt;
    moved_r    <= moved_nxt;
    fwd_hit_r  <= fwd_hit_nxt;
    fwd_data_r <= fwd_data_nxt;
    probe_ok_r <= probe_ok_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // requests are taken only between operations
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[rtl/mlds_checker.sv]
// port-level checks for the multi-list deque splice manager, bound to the top level
module mlds_checker
  import mlds_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  logic in_acc;

  assign in_acc = in_tvalid && in_tready;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one request at a time: busy right after an accept
  a_busy_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("request taken while an operation is in flight");

  // a result only comes out of a busy cycle
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without an operation");

  // reset empties the output and starts the clearing pass
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("ports active right after reset");

endmodule

bind multi_list_deque_splice_manager_core mlds_checker u_mlds_checker (.*);
